FILE: src/evit_pkg.sv
package evit_pkg;

	localparam int NORM_W        = 64;
	localparam int LZ_W          = 6;
	localparam int LOG_FRAC_BITS = 40;
	localparam int T_W           = LOG_FRAC_BITS + LZ_W;
	localparam int RATE_W        = 24;
	localparam int OUT_W         = 32;
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
	localparam logic [RATE_W-1:0] INV_RATE_RESET = 24'd65536;

	typedef struct packed {
		logic [NORM_W-1:0]        m;
		logic [LOG_FRAC_BITS-1:0] frac;
		logic [LZ_W-1:0]          lz;
	} log_beat_t;

endpackage

FILE: src/evit_norm.sv
module evit_norm import evit_pkg::*; #(
	parameter int UNIFORM_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vin,
	input  logic [UNIFORM_BITS-1:0] u,
	output logic                    vout,
	output log_beat_t               dout
);

	localparam int PAD = NORM_W - 1 - UNIFORM_BITS;

	logic [UNIFORM_BITS:0] w;
	logic [NORM_W-1:0]     x_s  [0:LZ_W];
	logic [LZ_W-1:0]       lz_s [0:LZ_W];
	logic                  v_s  [0:LZ_W];

	assign w = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, u};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= {w, {PAD{1'b0}}};
			lz_s[0] <= '0;
		end
	end

	// binary leading-zero search, one shift size per stage
	for (genvar j = 0; j < LZ_W; j++) begin : g_step
		localparam int S = 2 ** (LZ_W - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (x_s[j][NORM_W-1 -: S] == '0) begin
					x_s[j+1]  <= x_s[j] << S;
					lz_s[j+1] <= lz_s[j] + LZ_W'(S);
				end else begin
					x_s[j+1]  <= x_s[j];
					lz_s[j+1] <= lz_s[j];
				end
			end
		end
	end

	assign vout      = v_s[LZ_W];
	assign dout.m    = x_s[LZ_W];
	assign dout.frac = '0;
	assign dout.lz   = lz_s[LZ_W];

endmodule

FILE: src/evit_sqr.sv
module evit_sqr import evit_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vin,
	input  log_beat_t din,
	output logic      vout,
	output log_beat_t dout
);

	logic [63:0]              p11_s1, p10_s1, p00_s1;
	logic [LOG_FRAC_BITS-1:0] frac_s1;
	logic [LZ_W-1:0]          lz_s1;
	logic                     v_s1, v_s2;
	log_beat_t                beat_s2;
	logic [127:0]             sq;
	logic [63:0]              hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p11_s1  <= din.m[63:32] * din.m[63:32];
			p10_s1  <= din.m[63:32] * din.m[31:0];
			p00_s1  <= din.m[31:0] * din.m[31:0];
			frac_s1 <= din.frac;
			lz_s1   <= din.lz;
		end
	end

	// square = p11<<64 + 2*p10<<32 + p00; keep top 64 bits, renormalize
	assign sq = {p11_s1, p00_s1} + {31'b0, p10_s1, 33'b0};
	assign hi = sq[127:64];

	always_ff @(posedge clk) begin
		if (en) begin
			beat_s2.m    <= hi[63] ? hi : {hi[62:0], sq[63]};
			beat_s2.frac <= {frac_s1[LOG_FRAC_BITS-2:0], hi[63]};
			beat_s2.lz   <= lz_s1;
		end
	end

	assign vout = v_s2;
	assign dout = beat_s2;

endmodule

FILE: src/evit_scale.sv
module evit_scale import evit_pkg::*; #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  log_beat_t         din,
	input  logic [RATE_W-1:0] inv_rate,
	output logic              vout,
	output logic [OUT_W-1:0]  exp_sample,
	output logic              saturated
);

	localparam int SH = 56 - OUT_FRAC_BITS;

	logic [T_W-1:0]   t_s1;
	logic [45:0]      a_s2, b_s2;
	logic [63:0]      c_s2, d_s2;
	logic [T_W-1:0]   n_s3;
	logic [37:0]      e_s4;
	logic [55:0]      f_s4;
	logic [69:0]      p_s5;
	logic [OUT_W-1:0] x_s6;
	logic             sat_s6;
	logic [5:0]       v_q;
	logic [127:0]     ln_sum;
	logic [71:0]      r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], vin};
		end
	end

	assign ln_sum = (128'(a_s2) << 64) + (128'(b_s2) << 32) + (128'(c_s2) << 32)
		+ 128'(d_s2);
	assign r = 72'(p_s5 >> SH) + 72'(p_s5[SH-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= {din.lz, {LOG_FRAC_BITS{1'b0}}} - {{LZ_W{1'b0}}, din.frac};
			a_s2   <= t_s1[45:32] * LN2_Q64[63:32];
			b_s2   <= t_s1[45:32] * LN2_Q64[31:0];
			c_s2   <= t_s1[31:0] * LN2_Q64[63:32];
			d_s2   <= t_s1[31:0] * LN2_Q64[31:0];
			n_s3   <= ln_sum[64 +: T_W];
			e_s4   <= n_s3[45:32] * inv_rate;
			f_s4   <= n_s3[31:0] * inv_rate;
			p_s5   <= (70'(e_s4) << 32) + 70'(f_s4);
			sat_s6 <= |r[71:OUT_W];
			x_s6   <= (|r[71:OUT_W]) ? '1 : r[OUT_W-1:0];
		end
	end

	assign vout       = v_q[5];
	assign exp_sample = x_s6;
	assign saturated  = sat_s6;

endmodule

FILE: src/exponential_variate_inverse_transform.sv
// Exponential variate generator, x = -ln(1 - u) * inv_rate.
// Input channel: uniform_word (u as Q0.UNIFORM_BITS) with in_valid/in_ready.
// Output channel: exp_sample (unsigned Q(32-OUT_FRAC_BITS).OUT_FRAC_BITS) and
// saturated, with out_valid/out_ready. One result beat per input beat, in order.
// inv_rate (unsigned Q8.16) is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the pipeline is empty; the block does not enforce it.
// Pipeline from input beat to output beat: 7 normalize stages,
// 40 squaring steps of 2 stages each (three 32x32 products, then a 128-bit add),
// and 6 stages for the log assembly, ln2 product, rate product and rounding.
// Throughput: one beat per cycle unless the receiver stalls. Every stage
// holds a valid bit; the whole pipeline advances whenever the output register
// is empty or being taken, and in_ready follows that same enable.
// When the receiver stalls, the pipeline freezes with the result held on the
// output; nothing is dropped or repeated.
// Reset clears all valid bits and loads inv_rate with 1.0; in_ready stays low
// during reset and rises once the run_q register is set after reset is released.
module exponential_variate_inverse_transform import evit_pkg::*; #(
	parameter int UNIFORM_BITS  = 32,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [RATE_W-1:0]       cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [UNIFORM_BITS-1:0] uniform_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OUT_W-1:0]        exp_sample,
	output logic                    saturated
);

	logic [RATE_W-1:0] inv_rate_q;
	logic              run_q;
	logic              en;
	log_beat_t         chain [0:LOG_FRAC_BITS];
	logic              chain_v [0:LOG_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_rate_q <= INV_RATE_RESET;
		end else if (cfg_wr_en) begin
			inv_rate_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en && run_q;

	evit_norm #(.UNIFORM_BITS(UNIFORM_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (in_valid && run_q),
		.u      (uniform_word),
		.vout   (chain_v[0]),
		.dout   (chain[0])
	);

	for (genvar i = 0; i < LOG_FRAC_BITS; i++) begin : g_sqr
		evit_sqr u_sqr (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (chain_v[i]),
			.din    (chain[i]),
			.vout   (chain_v[i+1]),
			.dout   (chain[i+1])
		);
	end

	evit_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vin        (chain_v[LOG_FRAC_BITS]),
		.din        (chain[LOG_FRAC_BITS]),
		.inv_rate   (inv_rate_q),
		.vout       (out_valid),
		.exp_sample (exp_sample),
		.saturated  (saturated)
	);

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> exp_sample == '1)
		else $error("saturated result not clamped");

	a_norm_msb: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[0] |-> chain[0].m[NORM_W-1] && chain[0].lz <= LZ_W'(UNIFORM_BITS))
		else $error("normalizer output not normalized");

	a_log_msb: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[LOG_FRAC_BITS] |-> chain[LOG_FRAC_BITS].m[NORM_W-1])
		else $error("squaring chain lost normalization");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import evit_pkg::*; ();

	localparam int UBITS      = 32;
	localparam int FRAC_OUT   = 16;
	localparam int LATENCY    = 93;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [OUT_W-1:0] sample;
		logic             sat;
	} sample_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [RATE_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [UBITS-1:0] uniform_word;
	logic out_valid;
	logic out_ready;
	logic [OUT_W-1:0] exp_sample;
	logic saturated;

	logic [RATE_W-1:0] rate_shadow;
	sample_t expected_q[$];
	int errors;
	int idle_cycles;
	int hold_off;
	bit hold_enable;
	bit timed_out;

	exponential_variate_inverse_transform #(
		.UNIFORM_BITS(UBITS),
		.OUT_FRAC_BITS(FRAC_OUT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.uniform_word(uniform_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.exp_sample(exp_sample),
		.saturated(saturated)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// -log2(w / 2^UBITS) in Q6.40 by normalize and repeated squaring
	function automatic logic [63:0] neg_log2(input logic [63:0] w);
		int k;
		logic [63:0] m;
		logic [127:0] sq;
		logic [63:0] fr;
		k = 0;
		fr = '0;
		while (k < 63 && (w >> (k + 1)) != 0)
			k++;
		m = w << (63 - k);
		for (int i = 0; i < LOG_FRAC_BITS; i++) begin
			sq = {64'd0, m} * {64'd0, m};
			fr = fr << 1;
			if (sq[127]) begin
				fr[0] = 1'b1;
				m = sq[127:64];
			end else begin
				m = sq[126:63];
			end
		end
		return (64'(UBITS - k) << LOG_FRAC_BITS) - fr;
	endfunction

	function automatic sample_t exp_variate(input logic [UBITS-1:0] u,
			input logic [RATE_W-1:0] rate);
		logic [63:0] w, t, n;
		logic [127:0] p;
		logic [127:0] r;
		sample_t s;
		int sh;
		sh = 56 - FRAC_OUT;
		w = (64'd1 << UBITS) - 64'(u);
		t = neg_log2(w);
		p = {64'd0, t} * {64'd0, LN2_Q64};
		n = p[127:64];
		p = {64'd0, n} * {104'd0, rate};
		r = (p >> sh) + ((p >> (sh - 1)) & 128'd1);
		s.sat = r > 128'hFFFF_FFFF;
		s.sample = s.sat ? 32'hFFFF_FFFF : r[31:0];
		return s;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat", 64'(exp_sample), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (exp_sample !== want.sample)
					report_mismatch("exp_sample", 64'(exp_sample), 64'(want.sample));
				if (saturated !== want.sat)
					report_mismatch("saturated", 64'(saturated), 64'(want.sat));
			end
		end
	end

	// receiver stall pattern, with a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_enable) begin
			hold_enable <= 1'b0;
			hold_off <= 400;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= (hold_off == 1);
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 30);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
				timed_out <= 1'b1;
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	int burst_left;

	task automatic send_uniform(input logic [UBITS-1:0] u);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		uniform_word <= u;
		expected_q.push_back(exp_variate(u, rate_shadow));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		rate_shadow = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [UBITS-1:0] rand_uniform();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 255);
			1: return ~32'($urandom_range(0, 255));
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [UBITS-1:0] pts[$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
			32'hC000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678};
		foreach (pts[i])
			send_uniform(pts[i]);
	endtask

	task automatic test_rates();
		logic [RATE_W-1:0] rates[$] = '{24'd1, 24'hFF_FFFF, 24'h80_0000, 24'd65535,
			24'h01_0001, 24'h55_AAAA};
		foreach (rates[r]) begin
			write_rate(rates[r]);
			test_directed();
			repeat (30) send_uniform(rand_uniform());
		end
	endtask

	task automatic test_backpressure();
		hold_enable <= 1'b1;
		repeat (250) send_uniform(rand_uniform());
	endtask

	task automatic test_random();
		logic [RATE_W-1:0] r;
		for (int ph = 0; ph < 6; ph++) begin
			r = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(1, 200)) :
				RATE_W'($urandom_range(1, 24'hFF_FFFF));
			write_rate(r);
			repeat (225) send_uniform(rand_uniform());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		uniform_word = '0;
		errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		hold_enable = 1'b0;
		timed_out = 1'b0;
		burst_left = 0;
		rate_shadow = INV_RATE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rates();
		write_rate(INV_RATE_RESET);
		test_backpressure();
		test_random();
		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
src/evit_pkg.sv
src/evit_norm.sv
src/evit_sqr.sv
src/evit_scale.sv
src/exponential_variate_inverse_transform.sv
test/tb_top.sv
